[rtl/acff_pkg.sv]
// Shared types and constants for the AT-content fluctuation fingerprint block.
package acff_pkg;

    localparam int MaxWindow  = 256;
    localparam int MaxStep    = 256;
    localparam int MaxUnitLen = 1024;
    localparam int MaxFpBits  = 64;
    localparam int MaxReadLen = 65536;

    localparam int PosW   = $clog2(MaxReadLen + 1);
    localparam int FlagAw = $clog2(MaxWindow);
    localparam int CntAw  = $clog2(MaxStep);
    localparam int HistAw = $clog2(MaxUnitLen);
    localparam int CntW   = 9;
    localparam int WinW   = 9;
    localparam int LenW   = 11;
    localparam int IdxW   = 16;
    localparam int FpW    = 64;
    localparam int NbW    = 7;

    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChLowerA = 8'h61;
    localparam logic [7:0] ChUpperT = 8'h54;
    localparam logic [7:0] ChLowerT = 8'h74;

    localparam logic [1:0] RegWinLen     = 2'd0;
    localparam logic [1:0] RegWinStep    = 2'd1;
    localparam logic [1:0] RegUnitLen    = 2'd2;
    localparam logic [1:0] RegUnitStride = 2'd3;

    typedef struct packed {
        logic [WinW-1:0] win;
        logic [WinW-1:0] step;
        logic [LenW-1:0] ulen;
        logic [LenW-1:0] stride;
    } cfg_t;

    typedef struct packed {
        logic [IdxW-1:0] start;
        logic [IdxW-1:0] idx;
        logic            ep;
    } unit_t;

    typedef struct packed {
        logic            vld;
        logic [IdxW-1:0] start;
        logic            ep;
    } pend_t;

    typedef struct packed {
        logic              we;
        logic [HistAw-1:0] addr;
        logic              din;
    } hist_wr_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_GATHER,
        BK_DONE
    } bk_state_t;

endpackage

[rtl/acff_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module acff_ram #(
    parameter int Width = 1,
    parameter int Depth = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/acff_fifo.sv]
// Small queue of pending alignment units between front and back.
module acff_fifo #(
    parameter int Depth = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  acff_pkg::unit_t            push_data,
    input  logic                       pop,
    output acff_pkg::unit_t            head,
    output logic                       not_empty,
    output logic [$clog2(Depth+1)-1:0] count
);
    import acff_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntQ = $clog2(Depth + 1);

    unit_t           mem_reg [Depth];
    logic [PtrW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [CntQ-1:0] cnt_reg, cnt_next;

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == PtrW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop) begin
            rp_next = (rp_reg == PtrW'(Depth - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    assign head      = mem_reg[rp_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;
endmodule

[rtl/acff_front.sv]
// Front: takes bases, keeps window counts, writes comparison bits, spots unit ends.
module acff_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  acff_pkg::cfg_t     cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_base_char,
    input  logic               s_last_of_read,
    input  acff_pkg::pend_t    pend,
    input  logic               room,
    output logic               push,
    output acff_pkg::unit_t    push_data,
    output acff_pkg::hist_wr_t hist_wr
);
    import acff_pkg::*;

    logic [PosW-1:0] pos_reg, pos_next;
    logic            ep_reg, ep_next;
    logic [LenW-1:0] phase_reg, phase_next;
    logic [IdxW-1:0] ucnt_reg, ucnt_next;

    logic              s2_vld_reg, s2_act_reg, s2_flag_reg, s2_old_en_reg;
    logic              s2_wr_en_reg, s2_cmp_en_reg, s2_fwd_reg, s2_clr_reg, s2_emit_reg;
    logic [HistAw-1:0] s2_s_reg;
    unit_t             s2_unit_reg;
    logic [CntW-1:0]   cnt_reg, wdata_reg;

    logic              acc, in_range, flag, has_old, has_s, has_cmp, emit, fwd, hazard;
    logic [PosW-1:0]   w_ext, st_ext, pos1, dif, s_cur, sm;
    logic [LenW-1:0]   cur_c;
    logic [PosW-1:0]   start_full;
    logic              old_q;
    logic [CntW-1:0]   prev_q, prev_v, cnt_new;
    logic              o_vld, o_ep;
    logic [IdxW-1:0]   o_start;
    logic [PosW:0]     lim;

    assign acc      = s_valid && s_ready;
    assign in_range = pos_reg < PosW'(MaxReadLen);
    assign flag     = (s_base_char == ChUpperA) || (s_base_char == ChLowerA)
                   || (s_base_char == ChUpperT) || (s_base_char == ChLowerT);
    assign w_ext    = PosW'(cfg.win);
    assign st_ext   = PosW'(cfg.step);
    assign has_old  = pos_reg >= w_ext;
    assign dif      = pos_reg - w_ext;
    assign pos1     = pos_reg + 1'b1;
    assign has_s    = pos1 >= w_ext;
    assign s_cur    = pos1 - w_ext;
    assign has_cmp  = s_cur >= st_ext;
    assign sm       = s_cur - st_ext;
    assign fwd      = s2_vld_reg && s2_wr_en_reg && (s2_s_reg[CntAw-1:0] == sm[CntAw-1:0]);
    assign cur_c    = (pos_reg == '0) ? cfg.ulen - 1'b1 : phase_reg;
    assign emit     = in_range && (cur_c == '0);
    assign start_full = pos1 - PosW'(cfg.ulen);

    // oldest unit still reading comparison history
    always_comb begin
        o_vld   = pend.vld;
        o_start = pend.start;
        o_ep    = pend.ep;
        if (!pend.vld && s2_vld_reg && s2_emit_reg) begin
            o_vld   = 1'b1;
            o_start = s2_unit_reg.start;
            o_ep    = s2_unit_reg.ep;
        end
    end

    assign lim    = (PosW+1)'(o_start) + (PosW+1)'(MaxUnitLen - 1) + (PosW+1)'(cfg.win);
    assign hazard = o_vld && ((o_ep != ep_reg) || ({1'b0, pos_reg} > lim));
    assign s_ready = room && !hazard;

    always_comb begin
        pos_next   = pos_reg;
        ep_next    = ep_reg;
        phase_next = phase_reg;
        ucnt_next  = ucnt_reg;
        if (acc) begin
            if (in_range) begin
                pos_next   = pos1;
                phase_next = emit ? cfg.stride - 1'b1 : cur_c - 1'b1;
                if (emit) begin
                    ucnt_next = ucnt_reg + 1'b1;
                end
            end
            if (s_last_of_read) begin
                pos_next  = '0;
                ucnt_next = '0;
                ep_next   = ~ep_reg;
            end
        end
    end

    acff_ram #(.Width(1), .Depth(MaxWindow)) u_flags (
        .aclk  (aclk),
        .we    (acc && in_range),
        .waddr (pos_reg[FlagAw-1:0]),
        .wdata (flag),
        .raddr (dif[FlagAw-1:0]),
        .rdata (old_q)
    );

    acff_ram #(.Width(CntW), .Depth(MaxStep)) u_counts (
        .aclk  (aclk),
        .we    (s2_vld_reg && s2_wr_en_reg),
        .waddr (s2_s_reg[CntAw-1:0]),
        .wdata (cnt_new),
        .raddr (sm[CntAw-1:0]),
        .rdata (prev_q)
    );

    assign prev_v  = s2_fwd_reg ? wdata_reg : prev_q;
    assign cnt_new = cnt_reg + CntW'(s2_flag_reg) - CntW'(s2_old_en_reg && old_q);

    assign hist_wr.we   = s2_vld_reg && s2_cmp_en_reg;
    assign hist_wr.addr = s2_s_reg;
    assign hist_wr.din  = cnt_new >= prev_v;
    assign push         = s2_vld_reg && s2_emit_reg;
    assign push_data    = s2_unit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            ep_reg     <= 1'b0;
            ucnt_reg   <= '0;
            s2_vld_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            pos_reg    <= pos_next;
            ep_reg     <= ep_next;
            ucnt_reg   <= ucnt_next;
            s2_vld_reg <= acc;
            if (s2_vld_reg && s2_clr_reg) begin
                cnt_reg <= '0;
            end else if (s2_vld_reg && s2_act_reg) begin
                cnt_reg <= cnt_new;
            end
        end
        phase_reg <= phase_next;
        if (s2_vld_reg) begin
            wdata_reg <= cnt_new;
        end
        if (acc) begin
            s2_act_reg    <= in_range;
            s2_flag_reg   <= flag;
            s2_old_en_reg <= in_range && has_old;
            s2_wr_en_reg  <= in_range && has_s;
            s2_cmp_en_reg <= in_range && has_s && has_cmp;
            s2_fwd_reg    <= fwd;
            s2_s_reg      <= s_cur[HistAw-1:0];
            s2_clr_reg    <= s_last_of_read;
            s2_emit_reg   <= emit;
            s2_unit_reg   <= '{start: start_full[IdxW-1:0], idx: ucnt_reg, ep: ep_reg};
        end
    end
endmodule

[rtl/acff_back.sv]
// Back: gathers a unit's comparison bits from history and presents the result.
module acff_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  acff_pkg::cfg_t     cfg,
    input  acff_pkg::hist_wr_t hist_wr,
    input  acff_pkg::unit_t    head,
    input  logic               not_empty,
    output logic               pop,
    output acff_pkg::pend_t    busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [63:0]        m_fingerprint,
    output logic [6:0]         m_fingerprint_bits,
    output logic [15:0]        m_unit_index
);
    import acff_pkg::*;

    bk_state_t       state_reg, state_next;
    unit_t           cur_reg;
    logic [LenW-1:0] off_reg;
    logic [NbW-1:0]  iss_reg;
    logic [FpW-1:0]  fp_reg;
    logic            rv_reg;
    logic            out_vld_reg;
    logic [FpW-1:0]  out_fp_reg;
    logic [NbW-1:0]  out_nb_reg;
    logic [IdxW-1:0] out_idx_reg;

    logic            fits, more, issue, load;
    logic [LenW-1:0] lim, st_ext;
    logic [IdxW-1:0] raddr_full;
    logic            rbit;

    assign st_ext     = LenW'(cfg.step);
    assign fits       = cfg.ulen >= LenW'(cfg.win);
    assign lim        = cfg.ulen - LenW'(cfg.win);
    assign more       = fits && (off_reg <= lim) && (iss_reg < NbW'(MaxFpBits));
    assign raddr_full = cur_reg.start + IdxW'(off_reg);

    acff_ram #(.Width(1), .Depth(MaxUnitLen)) u_hist (
        .aclk  (aclk),
        .we    (hist_wr.we),
        .waddr (hist_wr.addr),
        .wdata (hist_wr.din),
        .raddr (raddr_full[HistAw-1:0]),
        .rdata (rbit)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (not_empty) begin
                    state_next = BK_GATHER;
                end
            end
            BK_GATHER: begin
                if (!more && !rv_reg) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!out_vld_reg || m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop   = 1'b0;
        issue = 1'b0;
        load  = 1'b0;
        case (state_reg)
            BK_IDLE:   pop   = not_empty;
            BK_GATHER: issue = more;
            BK_DONE:   load  = !out_vld_reg || m_ready;
            default: ;
        endcase
    end

    always_comb begin
        busy = '{vld: 1'b0, start: head.start, ep: head.ep};
        if (state_reg == BK_GATHER) begin
            busy = '{vld: 1'b1, start: cur_reg.start, ep: cur_reg.ep};
        end else if (not_empty) begin
            busy.vld = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            rv_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= issue;
            if (load) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
        if (pop) begin
            cur_reg <= head;
            off_reg <= st_ext;
            iss_reg <= NbW'(1);
            fp_reg  <= FpW'(1);
        end else begin
            if (issue) begin
                off_reg <= off_reg + st_ext;
                iss_reg <= iss_reg + 1'b1;
            end
            if (rv_reg) begin
                fp_reg <= {fp_reg[FpW-2:0], rbit};
            end
        end
        if (load) begin
            out_fp_reg  <= fp_reg;
            out_nb_reg  <= iss_reg;
            out_idx_reg <= cur_reg.idx;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_fingerprint      = out_fp_reg;
    assign m_fingerprint_bits = out_nb_reg;
    assign m_unit_index       = out_idx_reg;
endmodule

[rtl/at_content_fluctuation_fingerprint.sv]
// Top level of the AT-content fluctuation fingerprint block.
//  channel  | direction | handshake          | payload
//  s_       | in        | s_valid / s_ready  | s_base_char, s_last_of_read
//  m_       | out       | m_valid / m_ready  | m_fingerprint, m_fingerprint_bits, m_unit_index
//  apb      | in        | psel/penable/pready| paddr, pwrite, pwdata, prdata
// Bases are taken one per cycle while s_ready is high; the front runs a two-stage
// pipeline over two small RAMs. Each fingerprint is gathered in the back with one
// history read per bit; bases keep flowing while the back works unless the unit queue
// fills or a queued unit's history slots would be overwritten. Reset is synchronous,
// active low, and needs no clearing pass.
module at_content_fluctuation_fingerprint #(
    parameter int QueueDepth = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_base_char,
    input  logic        s_last_of_read,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_fingerprint,
    output logic [6:0]  m_fingerprint_bits,
    output logic [15:0] m_unit_index,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import acff_pkg::*;

    localparam int CntQ = $clog2(QueueDepth + 1);

    logic [WinW-1:0] win_reg, step_reg;
    logic [LenW-1:0] ulen_reg, stride_reg;
    cfg_t            cfg;
    logic            wr;
    logic [1:0]      ridx;

    logic            push, pop, not_empty, room;
    unit_t           push_data, head;
    pend_t           busy;
    hist_wr_t        hist_wr;
    logic [CntQ-1:0] count;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= WinW'(10);
            step_reg   <= WinW'(5);
            ulen_reg   <= LenW'(100);
            stride_reg <= LenW'(20);
        end else if (wr) begin
            case (ridx)
                RegWinLen:     win_reg    <= pwdata[WinW-1:0];
                RegWinStep:    step_reg   <= pwdata[WinW-1:0];
                RegUnitLen:    ulen_reg   <= pwdata[LenW-1:0];
                RegUnitStride: stride_reg <= pwdata[LenW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            RegWinLen:     prdata = 32'(win_reg);
            RegWinStep:    prdata = 32'(step_reg);
            RegUnitLen:    prdata = 32'(ulen_reg);
            RegUnitStride: prdata = 32'(stride_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        cfg.win    = (win_reg == '0) ? WinW'(1)
                   : (win_reg > WinW'(MaxWindow)) ? WinW'(MaxWindow) : win_reg;
        cfg.step   = (step_reg == '0) ? WinW'(1)
                   : (step_reg > WinW'(MaxStep)) ? WinW'(MaxStep) : step_reg;
        cfg.ulen   = (ulen_reg == '0) ? LenW'(1)
                   : (ulen_reg > LenW'(MaxUnitLen)) ? LenW'(MaxUnitLen) : ulen_reg;
        cfg.stride = (stride_reg == '0) ? LenW'(1) : stride_reg;
    end

    assign room = count <= CntQ'(QueueDepth - 2);

    acff_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_base_char    (s_base_char),
        .s_last_of_read (s_last_of_read),
        .pend           (busy),
        .room           (room),
        .push           (push),
        .push_data      (push_data),
        .hist_wr        (hist_wr)
    );

    acff_fifo #(.Depth(QueueDepth)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (count)
    );

    acff_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg),
        .hist_wr            (hist_wr),
        .head               (head),
        .not_empty          (not_empty),
        .pop                (pop),
        .busy               (busy),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_fingerprint      (m_fingerprint),
        .m_fingerprint_bits (m_fingerprint_bits),
        .m_unit_index       (m_unit_index)
    );
endmodule
